>>> rtl/mmn_pkg.sv
package mmn_pkg;

  localparam int SET_DEPTH = 64;
  localparam int SMP_W     = 16;
  localparam int Q_W       = 16;
  localparam int IDX_W     = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int BIT_W     = $clog2(Q_W);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_PUSH
  } mmn_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic div_init;
    logic div_step;
    logic push;
  } mmn_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
    logic last_item;
  } mmn_sts_t;

endpackage

>>> rtl/min_max_normalizer.sv
// Samples load at one per cycle while in_tready is high; in_tready is low while the stored set
// drains, and a sample marked last starts the drain. Each result takes a read, a set-up, the
// bit-serial divider steps and an output load; the divider steps are skipped when the range is
// zero or the sample equals the maximum. The output load waits until the previous result is taken.
// Synchronous active-low reset empties the set and clears the output valid flag.
module min_max_normalizer
  import mmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [15:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata, // [15:0] norm_value
  output logic        out_tlast,
  output logic [1:0]  out_tuser  // [0] all_equal, [1] overflowed
);

  mmn_cmd_t cmd;
  mmn_sts_t sts;

  mmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmn_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample ($signed(in_tdata[SMP_W-1:0])),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_norm  (out_tdata[Q_W-1:0]),
    .out_end   (out_tlast),
    .out_equal (out_tuser[0]),
    .out_ovf   (out_tuser[1])
  );

endmodule

>>> rtl/mmn_ctrl.sv
module mmn_ctrl
  import mmn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  mmn_sts_t   sts,
  output mmn_cmd_t   cmd
);

  mmn_state_t state_r;
  mmn_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.skip ? ST_PUSH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = sts.last_item ? ST_LOAD : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/mmn_datapath.sv
module mmn_datapath
  import mmn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [SMP_W-1:0] in_sample,
  input  mmn_cmd_t                cmd,
  output mmn_sts_t                sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [Q_W-1:0]          out_norm,
  output logic                    out_end,
  output logic                    out_equal,
  output logic                    out_ovf
);

  logic [SMP_W-1:0]        mem [SET_DEPTH];
  logic [SMP_W-1:0]        rd_data_r;
  logic [CNT_W-1:0]        fill_r;
  logic [CNT_W-1:0]        fill_nxt;
  logic signed [SMP_W-1:0] min_r;
  logic signed [SMP_W-1:0] min_nxt;
  logic signed [SMP_W-1:0] max_r;
  logic signed [SMP_W-1:0] max_nxt;
  logic                    drop_r;
  logic                    drop_nxt;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [IDX_W-1:0]        rd_idx_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [Q_W-1:0]          out_norm_r;
  logic                    out_end_r;
  logic                    out_equal_r;
  logic                    out_ovf_r;
  logic [SMP_W-1:0]        rem_r;
  logic [Q_W-1:0]          quo_r;
  logic [BIT_W-1:0]        bit_r;
  logic                    sat_r;
  logic                    zero_r;
  logic                    not_full;
  logic [SMP_W-1:0]        range_w;
  logic [SMP_W-1:0]        diff_w;
  logic [SMP_W:0]          rem2_w;
  logic                    ge_w;
  logic                    range_zero;
  logic                    last_item;

  assign not_full   = fill_r < CNT_W'(SET_DEPTH);
  assign range_w    = SMP_W'(max_r - min_r);
  assign range_zero = (range_w == '0);
  assign diff_w     = SMP_W'($signed(rd_data_r) - min_r);
  assign rem2_w     = {rem_r, 1'b0};
  assign ge_w       = rem2_w >= {1'b0, range_w};
  assign last_item  = (CNT_W'(rd_idx_r) + CNT_W'(1)) == fill_r;

  assign sts.skip      = range_zero || (diff_w == range_w);
  assign sts.div_last  = (bit_r == BIT_W'(Q_W - 1));
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.last_item = last_item;

  always_comb begin
    fill_nxt      = fill_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    drop_nxt      = drop_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      if (not_full) begin
        fill_nxt = fill_r + CNT_W'(1);
        if (fill_r == '0) begin
          min_nxt = in_sample;
          max_nxt = in_sample;
        end else begin
          if (in_sample < min_r) begin
            min_nxt = in_sample;
          end
          if (in_sample > max_r) begin
            max_nxt = in_sample;
          end
        end
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
      if (last_item) begin
        fill_nxt   = '0;
        min_nxt    = '0;
        max_nxt    = '0;
        drop_nxt   = 1'b0;
        rd_idx_nxt = '0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      min_r       <= '0;
      max_r       <= '0;
      drop_r      <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      drop_r      <= drop_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && not_full) begin
      mem[fill_r[IDX_W-1:0]] <= in_sample;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Restoring division of diff * 2^16 by the range, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= diff_w;
      quo_r  <= '0;
      bit_r  <= '0;
      zero_r <= range_zero;
      sat_r  <= !range_zero && (diff_w == range_w);
    end else if (cmd.div_step) begin
      rem_r <= ge_w ? SMP_W'(rem2_w - {1'b0, range_w}) : rem2_w[SMP_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge_w};
      bit_r <= bit_r + BIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_norm_r  <= zero_r ? '0 : (sat_r ? '1 : quo_r);
      out_end_r   <= last_item;
      out_equal_r <= range_zero;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_norm  = out_norm_r;
  assign out_end   = out_end_r;
  assign out_equal = out_equal_r;
  assign out_ovf   = out_ovf_r;

endmodule
